### src/frt_pkg.sv
// Shared types, defaults and codes for the fragment reassembly tracker.
package frt_pkg;

  // Default sizing
  localparam int NUM_CONTEXTS_DEF = 8;
  localparam int FRAG_PAYLOAD_DEF = 200;
  localparam int MAX_FRAGS_DEF    = 64;

  // Configuration register indexes
  localparam logic [1:0] CFG_EXPECTED_VERSION = 2'd0;
  localparam logic [1:0] CFG_TIMEOUT_TICKS    = 2'd1;
  localparam logic [1:0] CFG_MAX_BUNDLE_LEN   = 2'd2;

  // Configuration register reset values
  localparam logic [7:0]  EXPECTED_VERSION_RST = 8'd1;
  localparam logic [31:0] TIMEOUT_TICKS_RST    = 32'd5000;
  localparam logic [31:0] MAX_BUNDLE_LEN_RST   = 32'd65535;

  // Input action codes
  localparam logic ACT_FRAGMENT = 1'b0;
  localparam logic ACT_TICK     = 1'b1;

  typedef enum logic [3:0] {
    ST_STORED      = 4'd0,
    ST_DUPLICATE   = 4'd1,
    ST_OUT_OF_BNDS = 4'd2,
    ST_COMPLETE    = 4'd3,
    ST_SINGLE      = 4'd4,
    ST_TOO_LARGE   = 4'd5,
    ST_NO_CONTEXT  = 4'd6,
    ST_BAD_VERSION = 4'd7,
    ST_TICK        = 4'd8
  } status_t;

  typedef struct packed {
    logic [7:0]  expected_version;
    logic [31:0] timeout_ticks;
    logic [31:0] max_bundle_len;
  } cfg_t;

  typedef struct packed {
    logic        action;
    logic [7:0]  src_node;
    logic [7:0]  version;
    logic        first_flag;
    logic        last_flag;
    logic [15:0] frag_id;
    logic [15:0] frag_offset;
    logic [15:0] frag_bytes;
    logic [31:0] total_size;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic        store_payload;
    logic [2:0]  ctx_index;
    logic [7:0]  done_src_addr;
    logic [31:0] done_length;
    logic [3:0]  expired_count;
  } result_t;

endpackage

### src/frt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module frt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/frt_core.sv
// Sequencer and shared datapath: slot walk, index divide, bitmap and byte checks.
module frt_core import frt_pkg::*; #(
  parameter int NUM_CONTEXTS = NUM_CONTEXTS_DEF,
  parameter int FRAG_PAYLOAD = FRAG_PAYLOAD_DEF,
  parameter int MAX_FRAGS    = MAX_FRAGS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    start,
  input  item_t   item,
  output logic    busy,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res
);

  localparam int IDXW     = NUM_CONTEXTS > 1 ? $clog2(NUM_CONTEXTS) : 1;
  localparam int CNTW     = $clog2(NUM_CONTEXTS + 1);
  localparam int MAP_BITS = MAX_FRAGS < 64 ? MAX_FRAGS : 64;
  localparam int MAPW     = MAP_BITS > 1 ? $clog2(MAP_BITS) : 1;
  localparam logic [32:0] RECIP   = 33'((64'd1 << 32) / FRAG_PAYLOAD);
  localparam logic [15:0] DIVISOR = 16'(FRAG_PAYLOAD);

  typedef struct packed {
    logic [7:0]          source;
    logic [15:0]         bundle_id;
    logic [31:0]         total_bytes;
    logic [31:0]         bytes_seen;
    logic [31:0]         open_tick;
    logic [MAP_BITS-1:0] seen_map;
  } entry_t;

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_WALK     = 9'b000000010,
    S_DECIDE   = 9'b000000100,
    S_DIV_MUL  = 9'b000001000,
    S_DIV_BACK = 9'b000010000,
    S_DIV_FIX  = 9'b000100000,
    S_CHECK    = 9'b001000000,
    S_FINISH   = 9'b010000000,
    S_DONE     = 9'b100000000
  } state_t;

  state_t                  state;
  logic [CNTW-1:0]         walk_cnt;
  logic [CNTW-1:0]         walk_prev;
  logic [IDXW-1:0]         walk_slot;
  logic [NUM_CONTEXTS-1:0] in_use;
  logic [31:0]             now_ticks;
  item_t                   cur;
  entry_t                  ent;
  entry_t                  rd_ent;
  logic [IDXW-1:0]         slot;
  logic [IDXW-1:0]         spare_slot;
  logic                    hit_found;
  logic                    spare_found;
  logic [15:0]             fidx;
  logic [48:0]             prod;
  logic [32:0]             mul_a;
  logic [15:0]             mul_b;
  logic [31:0]             age;
  logic                    slot_expired;
  logic                    slot_live;
  logic                    key_match;
  logic [16:0]             rem;
  logic                    in_map;
  logic                    seen;
  logic [31:0]             end_pos;
  logic [32:0]             byte_sum;
  logic [5:0]              slot_wide;
  logic                    ram_we;
  logic [IDXW-1:0]         ram_raddr;

  assign busy      = (state != S_IDLE);
  assign res_valid = (state == S_DONE);

  // Walk bookkeeping: read address runs one slot ahead of the processed slot
  assign walk_prev = walk_cnt - CNTW'(1);
  assign walk_slot = walk_prev[IDXW-1:0];
  assign ram_raddr = walk_cnt[IDXW-1:0];
  assign ram_we    = (state == S_FINISH);

  frt_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (NUM_CONTEXTS)
  ) u_ctx_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot),
    .wdata (ent),
    .raddr (ram_raddr),
    .rdata (rd_ent)
  );

  // Per-slot expiry and key compare on the entry read back
  assign age          = now_ticks - rd_ent.open_tick;
  assign slot_expired = in_use[walk_slot] && (age > cfg.timeout_ticks);
  assign slot_live    = in_use[walk_slot] && !slot_expired;
  assign key_match    = (rd_ent.source == cur.src_node) && (rd_ent.bundle_id == cur.frag_id);

  // Shared multiplier: reciprocal multiply, then quotient times divisor
  always_comb begin
    if (state == S_DIV_BACK) begin
      mul_a = {17'd0, prod[47:32]};
      mul_b = DIVISOR;
    end else begin
      mul_a = RECIP;
      mul_b = cur.frag_offset;
    end
  end

  assign rem = {1'b0, cur.frag_offset} - prod[16:0];

  // Bitmap and bounds checks
  assign in_map    = fidx < 16'(MAP_BITS);
  assign seen      = in_map && ent.seen_map[fidx[MAPW-1:0]];
  assign end_pos   = {15'd0, ({1'b0, cur.frag_offset} + {1'b0, cur.frag_bytes})};
  assign byte_sum  = {1'b0, ent.bytes_seen} + {17'd0, cur.frag_bytes};
  assign slot_wide = 6'(slot);

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_use    <= '0;
      now_ticks <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_WALK;
          end
        end
        S_WALK: begin
          if (walk_cnt != '0 && slot_expired) begin
            in_use[walk_slot] <= 1'b0;
          end
          if (walk_cnt == CNTW'(NUM_CONTEXTS)) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (cur.action == ACT_TICK) begin
            now_ticks <= now_ticks + 32'd1;
            state     <= S_DONE;
          end else if (cur.version != cfg.expected_version ||
                       (cur.first_flag && cur.last_flag)) begin
            state <= S_DONE;
          end else if (!hit_found && !spare_found) begin
            state <= S_DONE;
          end else begin
            if (!hit_found) begin
              in_use[spare_slot] <= 1'b1;
            end
            state <= S_DIV_MUL;
          end
        end
        S_DIV_MUL:  state <= S_DIV_BACK;
        S_DIV_BACK: state <= S_DIV_FIX;
        S_DIV_FIX:  state <= S_CHECK;
        S_CHECK:    state <= S_FINISH;
        S_FINISH: begin
          if (ent.bytes_seen >= ent.total_bytes) begin
            in_use[slot] <= 1'b0;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        walk_cnt    <= '0;
        hit_found   <= 1'b0;
        spare_found <= 1'b0;
        if (start) begin
          cur <= item;
          res <= '{status: ST_STORED, default: '0};
        end
      end
      S_WALK: begin
        walk_cnt <= walk_cnt + CNTW'(1);
        if (walk_cnt != '0) begin
          if (slot_expired && res.expired_count != 4'hF) begin
            res.expired_count <= res.expired_count + 4'd1;
          end
          if (slot_live) begin
            if (!hit_found && key_match) begin
              hit_found <= 1'b1;
              slot      <= walk_slot;
              ent       <= rd_ent;
            end
          end else if (!spare_found) begin
            spare_found <= 1'b1;
            spare_slot  <= walk_slot;
          end
        end
      end
      S_DECIDE: begin
        if (cur.action == ACT_TICK) begin
          res.status <= ST_TICK;
        end else if (cur.version != cfg.expected_version) begin
          res.status <= ST_BAD_VERSION;
        end else if (cur.first_flag && cur.last_flag) begin
          if (cur.total_size > cfg.max_bundle_len) begin
            res.status <= ST_TOO_LARGE;
          end else begin
            res.status        <= ST_SINGLE;
            res.done_src_addr <= cur.src_node;
            res.done_length   <= {16'd0, cur.frag_bytes};
          end
        end else if (!hit_found && !spare_found) begin
          res.status <= ST_NO_CONTEXT;
        end else if (!hit_found) begin
          // Claim the first free slot with a fresh entry
          slot            <= spare_slot;
          ent.source      <= cur.src_node;
          ent.bundle_id   <= cur.frag_id;
          ent.total_bytes <= cur.total_size;
          ent.bytes_seen  <= '0;
          ent.open_tick   <= now_ticks;
          ent.seen_map    <= '0;
        end
      end
      S_DIV_MUL: begin
        prod <= mul_a * {33'd0, mul_b};
      end
      S_DIV_BACK: begin
        fidx <= prod[47:32];
        prod <= mul_a * {33'd0, mul_b};
      end
      S_DIV_FIX: begin
        // Reciprocal estimate is at most one low
        if (rem >= {1'b0, DIVISOR}) begin
          fidx <= fidx + 16'd1;
        end
      end
      S_CHECK: begin
        res.ctx_index <= slot_wide[2:0];
        if (seen) begin
          res.status <= ST_DUPLICATE;
        end else if (end_pos <= ent.total_bytes) begin
          ent.bytes_seen    <= byte_sum[32] ? 32'hFFFF_FFFF : byte_sum[31:0];
          if (in_map) begin
            ent.seen_map[fidx[MAPW-1:0]] <= 1'b1;
          end
          res.store_payload <= 1'b1;
          res.status        <= ST_STORED;
        end else begin
          res.status <= ST_OUT_OF_BNDS;
        end
      end
      S_FINISH: begin
        if (ent.bytes_seen >= ent.total_bytes) begin
          if (ent.total_bytes > cfg.max_bundle_len) begin
            res.status <= ST_TOO_LARGE;
          end else begin
            res.status        <= ST_COMPLETE;
            res.done_src_addr <= ent.source;
            res.done_length   <= ent.total_bytes;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### src/fragment_reassembly_tracker_unit.sv
// Top level: configuration registers, input handshake, output register and core.
//
// Tracks reassembly of fragmented bundles in NUM_CONTEXTS context slots keyed by
// source address and fragment id. Each transfer in (a fragment or one time tick)
// first frees slots older than timeout_ticks, then yields exactly one result.
// The core walks the context RAM one slot per cycle through its single read port.
// A tick, a rejected fragment or a single-fragment bundle then goes straight to
// its result, while a tracked fragment also passes through the shared multiplier
// that turns the byte offset into a fragment index and through the bitmap and
// byte-count update.
// in_stall is high while an item is in work; a finished result waits in the
// output register while the next item is taken. The payload itself is not kept:
// store_payload tells the caller to write it to slot ctx_index at frag_offset.
module fragment_reassembly_tracker_unit import frt_pkg::*; #(
  parameter int NUM_CONTEXTS = NUM_CONTEXTS_DEF,
  parameter int FRAG_PAYLOAD = FRAG_PAYLOAD_DEF,
  parameter int MAX_FRAGS    = MAX_FRAGS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic [7:0]  src_node,
  input  logic [7:0]  version,
  input  logic        first_flag,
  input  logic        last_flag,
  input  logic [15:0] frag_id,
  input  logic [15:0] frag_offset,
  input  logic [15:0] frag_bytes,
  input  logic [31:0] total_size,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  status,
  output logic        store_payload,
  output logic [2:0]  ctx_index,
  output logic [7:0]  done_src_addr,
  output logic [31:0] done_length,
  output logic [3:0]  expired_count
);

  cfg_t    cfg;
  item_t   item;
  result_t res;
  logic    busy;
  logic    res_valid;
  logic    res_ready;
  logic    start;

  assign cfg_ready = 1'b1;
  assign in_stall  = busy;
  assign start     = in_valid && !busy;
  assign res_ready = !out_valid || !out_stall;

  assign item = '{
    action:      action,
    src_node:    src_node,
    version:     version,
    first_flag:  first_flag,
    last_flag:   last_flag,
    frag_id:     frag_id,
    frag_offset: frag_offset,
    frag_bytes:  frag_bytes,
    total_size:  total_size
  };

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.expected_version <= EXPECTED_VERSION_RST;
      cfg.timeout_ticks    <= TIMEOUT_TICKS_RST;
      cfg.max_bundle_len   <= MAX_BUNDLE_LEN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_EXPECTED_VERSION: cfg.expected_version <= cfg_data[7:0];
        CFG_TIMEOUT_TICKS:    cfg.timeout_ticks    <= cfg_data;
        CFG_MAX_BUNDLE_LEN:   cfg.max_bundle_len   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  frt_core #(
    .NUM_CONTEXTS (NUM_CONTEXTS),
    .FRAG_PAYLOAD (FRAG_PAYLOAD),
    .MAX_FRAGS    (MAX_FRAGS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .start     (start),
    .item      (item),
    .busy      (busy),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register: load a finished result, drop valid once transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      status        <= res.status;
      store_payload <= res.store_payload;
      ctx_index     <= res.ctx_index;
      done_src_addr <= res.done_src_addr;
      done_length   <= res.done_length;
      expired_count <= res.expired_count;
    end
  end

endmodule
